/* rtl/hrk_pkg.sv */
package hrk_pkg;

  localparam int UsageWords = 8;
  localparam int WordBits   = 32;
  localparam int CfgIdxW    = 3;

  localparam logic [CfgIdxW-1:0] REG_EVENT_FORMAT     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_COLUMN_OLD       = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_COLUMN_NEW       = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_COLUMN_EIGHT_BIT = 3'd3;

  localparam logic [1:0] FMT_EIGHT = 2'd0;
  localparam logic [1:0] FMT_NEW   = 2'd1;
  localparam logic [1:0] FMT_OLD   = 2'd2;

  localparam logic [23:0] EVT_NEW_BASE = 24'hF90000;
  localparam logic [23:0] EVT_NEW_UP   = 24'h000100;
  localparam logic [23:0] EVT_NEW_ALL  = 24'h008000;
  localparam logic [23:0] EVT_OLD_BASE = 24'hFF0000;
  localparam logic [7:0]  EVT_DOWN_BIT = 8'h80;
  localparam logic [31:0] W4_SHIFT_OFF = 32'hFFFFFFE3;
  localparam logic [7:0]  NO           = 8'hFF;

  typedef struct packed {
    logic [1:0] event_format;
    logic [1:0] column_old;
    logic [1:0] column_new;
    logic [1:0] column_eight_bit;
  } cfg_t;

  typedef struct packed {
    logic [7:0] modifier_bits;
    logic [7:0] key_code_0;
    logic [7:0] key_code_1;
    logic [7:0] key_code_2;
    logic [7:0] key_code_3;
    logic [7:0] key_code_4;
    logic [7:0] key_code_5;
  } report_t;

  function automatic logic is_shift(input logic [7:0] u);
    is_shift = (u >= 8'hE0) || (u >= 8'h82 && u <= 8'h84);
  endfunction

  // columns 0..3 packed high to low
  function automatic logic [31:0] rom_row(input logic [7:0] u);
    logic [31:0] r;
    case (u)
      8'h04: r = {8'o47, 8'o123, 8'o120, 8'o72};
      8'h05: r = {8'o71, 8'o114, 8'o154, 8'o32};
      8'h06: r = {8'o67, 8'o164, 8'o152, 8'o31};
      8'h07: r = {8'o51, 8'o163, 8'o122, 8'o73};
      8'h08: r = {8'o26, 8'o162, 8'o73, 8'o121};
      8'h09: r = {8'o52, 8'o13, 8'o123, 8'o60};
      8'h0A: r = {8'o53, 8'o113, 8'o124, 8'o74};
      8'h0B: r = {8'o54, 8'o53, 8'o125, 8'o61};
      8'h0C: r = {8'o33, 8'o32, 8'o100, 8'o110};
      8'h0D: r = {8'o55, 8'o153, 8'o126, 8'o75};
      8'h0E: r = {8'o56, 8'o33, 8'o127, 8'o62};
      8'h0F: r = {8'o57, 8'o73, 8'o130, 8'o76};
      8'h10: r = {8'o73, 8'o154, 8'o156, 8'o33};
      8'h11: r = {8'o72, 8'o54, 8'o155, 8'o46};
      8'h12: r = {8'o34, 8'o72, 8'o101, 8'o124};
      8'h13: r = {8'o35, 8'o172, 8'o102, 8'o111};
      8'h14: r = {8'o24, 8'o122, 8'o71, 8'o120};
      8'h15: r = {8'o27, 8'o12, 8'o74, 8'o106};
      8'h16: r = {8'o50, 8'o63, 8'o121, 8'o57};
      8'h17: r = {8'o30, 8'o112, 8'o75, 8'o122};
      8'h18: r = {8'o32, 8'o152, 8'o77, 8'o123};
      8'h19: r = {8'o70, 8'o14, 8'o153, 8'o45};
      8'h1A: r = {8'o25, 8'o62, 8'o72, 8'o105};
      8'h1B: r = {8'o66, 8'o64, 8'o151, 8'o44};
      8'h1C: r = {8'o31, 8'o52, 8'o76, 8'o107};
      8'h1D: r = {8'o65, 8'o124, 8'o150, 8'o30};
      8'h1E: r = {8'o2, 8'o121, 8'o44, 8'o145};
      8'h1F: r = {8'o3, 8'o61, 8'o45, 8'o133};
      8'h20: r = {8'o4, 8'o161, 8'o46, 8'o146};
      8'h21: r = {8'o5, 8'o11, 8'o47, 8'o134};
      8'h22: r = {8'o6, 8'o111, 8'o50, 8'o147};
      8'h23: r = {8'o7, 8'o51, 8'o51, 8'o135};
      8'h24: r = {8'o10, 8'o151, 8'o52, 8'o150};
      8'h25: r = {8'o11, 8'o31, 8'o53, 8'o136};
      8'h26: r = {8'o12, 8'o71, 8'o54, 8'o151};
      8'h27: r = {8'o13, 8'o171, 8'o55, 8'o137};
      8'h28: r = {8'o62, 8'o136, 8'o133, 8'o64};
      8'h29: r = {8'o23, 8'o143, 8'o43, 8'o160};
      8'h2A: r = {8'o46, 8'o23, 8'o117, 8'o56};
      8'h2B: r = {8'o22, 8'o22, 8'o70, 8'o117};
      8'h2C: r = {8'o77, 8'o134, 8'o173, 8'o21};
      8'h2D: r = {NO, 8'o131, 8'o56, 8'o152};
      8'h2E: r = {8'o14, 8'o126, 8'o57, 8'o140};
      8'h2F: r = {8'o36, NO, NO, NO};
      8'h30: r = {8'o37, NO, NO, NO};
      8'h31: r = {8'o40, 8'o37, 8'o106, 8'o141};
      8'h33: r = {8'o60, 8'o173, 8'o131, 8'o63};
      8'h34: r = {NO, 8'o133, 8'o132, 8'o77};
      8'h35: r = {NO, 8'o77, NO, 8'o153};
      8'h36: r = {8'o74, 8'o34, 8'o157, 8'o47};
      8'h37: r = {8'o75, 8'o74, 8'o160, 8'o34};
      8'h38: r = {8'o76, 8'o174, 8'o161, 8'o50};
      8'h39: r = {NO, NO, 8'o3, NO};
      8'h3A: r = {NO, NO, 8'o24, NO};
      8'h3B: r = {NO, NO, 8'o25, NO};
      8'h3C: r = {NO, NO, 8'o26, NO};
      8'h3D: r = {NO, NO, 8'o27, NO};
      8'h42: r = {NO, 8'o101, 8'o21, 8'o162};
      8'h43: r = {NO, 8'o1, 8'o22, 8'o163};
      8'h44: r = {NO, 8'o102, 8'o23, 8'o164};
      8'h45: r = {NO, 8'o2, NO, NO};
      8'h47: r = {NO, NO, 8'o6, NO};
      8'h48: r = {NO, 8'o170, NO, NO};
      8'h49: r = {8'o17, 8'o160, NO, 8'o126};
      8'h4A: r = {NO, NO, 8'o136, NO};
      8'h4C: r = {NO, 8'o157, NO, NO};
      8'h4D: r = {NO, 8'o156, 8'o20, 8'o24};
      8'h4E: r = {8'o45, NO, NO, 8'o10};
      8'h4F: r = {NO, 8'o17, 8'o137, NO};
      8'h50: r = {NO, 8'o117, 8'o135, NO};
      8'h51: r = {NO, 8'o176, 8'o165, NO};
      8'h52: r = {NO, 8'o106, 8'o107, NO};
      8'h54: r = {8'o41, NO, NO, NO};
      8'h56: r = {8'o42, NO, 8'o113, NO};
      8'h57: r = {8'o43, NO, 8'o63, NO};
      8'h58: r = {8'o63, 8'o36, 8'o177, 8'o100};
      8'h59: r = {NO, NO, 8'o166, NO};
      8'h5A: r = {NO, NO, 8'o167, NO};
      8'h5B: r = {NO, NO, 8'o170, NO};
      8'h5C: r = {NO, NO, 8'o140, NO};
      8'h5D: r = {NO, NO, 8'o141, NO};
      8'h5E: r = {NO, NO, 8'o142, NO};
      8'h5F: r = {NO, NO, 8'o110, NO};
      8'h60: r = {NO, NO, 8'o111, NO};
      8'h61: r = {NO, NO, 8'o112, NO};
      8'h62: r = {NO, NO, 8'o175, NO};
      8'h63: r = {NO, NO, 8'o176, NO};
      8'h65: r = {NO, 8'o141, 8'o10, 8'o15};
      8'h67: r = {NO, NO, 8'o62, NO};
      8'h75: r = {NO, 8'o116, 8'o1, 8'o52};
      8'h76: r = {NO, 8'o42, 8'o11, 8'o71};
      8'h78: r = {NO, 8'o67, 8'o114, 8'o37};
      8'h79: r = {NO, 8'o100, NO, 8'o104};
      8'h7A: r = {NO, NO, 8'o17, NO};
      8'h82: r = {NO, 8'o125, NO, 8'o3};
      8'h83: r = {NO, 8'o15, NO, NO};
      8'h84: r = {NO, 8'o3, NO, 8'o11};
      8'h85: r = {NO, NO, 8'o143, NO};
      8'h9A: r = {NO, 8'o46, 8'o12, NO};
      8'h9B: r = {8'o0, 8'o167, 8'o66, 8'o166};
      8'h9C: r = {8'o21, 8'o110, 8'o16, 8'o165};
      8'h9D: r = {8'o64, NO, NO, NO};
      8'h9E: r = {NO, 8'o47, 8'o41, 8'o167};
      8'h9F: r = {8'o44, NO, NO, 8'o113};
      8'hA0: r = {8'o20, 8'o107, NO, NO};
      8'hA1: r = {NO, 8'o40, 8'o13, 8'o2};
      8'hA2: r = {NO, 8'o50, 8'o15, 8'o161};
      8'hA4: r = {NO, 8'o120, NO, 8'o65};
      8'hA5: r = {NO, NO, 8'o134, NO};
      8'hB6: r = {NO, 8'o132, 8'o103, 8'o125};
      8'hB7: r = {NO, 8'o137, 8'o104, 8'o112};
      8'hB8: r = {NO, 8'o166, 8'o60, NO};
      8'hB9: r = {NO, 8'o146, 8'o61, NO};
      8'hBA: r = {NO, NO, 8'o65, NO};
      8'hC3: r = {8'o16, NO, NO, NO};
      8'hC9: r = {NO, NO, NO, 8'o154};
      8'hCB: r = {8'o61, 8'o21, NO, 8'o132};
      8'hCD: r = {NO, NO, 8'o64, NO};
      8'hCE: r = {8'o15, NO, NO, NO};
      8'hE0: r = {NO, 8'o20, 8'o34, 8'o20};
      8'hE1: r = {NO, 8'o24, 8'o147, 8'o43};
      8'hE2: r = {NO, 8'o45, 8'o33, 8'o5};
      8'hE3: r = {NO, 8'o5, 8'o32, 8'o17};
      8'hE4: r = {NO, 8'o26, 8'o35, 8'o6};
      8'hE5: r = {NO, 8'o25, 8'o162, 8'o35};
      8'hE6: r = {NO, 8'o165, 8'o36, 8'o22};
      8'hE7: r = {NO, 8'o65, 8'o37, 8'o7};
      8'hE8: r = {NO, 8'o145, 8'o7, 8'o4};
      8'hE9: r = {NO, 8'o175, 8'o40, 8'o23};
      8'hEA: r = {NO, 8'o104, 8'o146, 8'o16};
      8'hEB: r = {NO, 8'o155, 8'o164, 8'o51};
      8'hEC: r = {NO, 8'o44, NO, NO};
      8'hED: r = {NO, 8'o35, NO, NO};
      8'hEE: r = {NO, 8'o115, 8'o4, 8'o36};
      8'hEF: r = {NO, NO, 8'o5, NO};
      default: r = {NO, NO, NO, NO};
    endcase
    rom_row = r;
  endfunction

  function automatic logic [7:0] rom_read(input logic [7:0] u, input logic [1:0] col);
    logic [31:0] row;
    logic [7:0]  v;
    row = rom_row(u);
    case (col)
      2'd0: v = row[31:24];
      2'd1: v = row[23:16];
      2'd2: v = row[15:8];
      default: v = row[7:0];
    endcase
    rom_read = v;
  endfunction

endpackage

/* rtl/hrk_ram.sv */
module hrk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/hrk_core.sv */
module hrk_core
  import hrk_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        rpt_load,
  input  report_t     rpt,
  output logic        busy,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_event_code,
  output logic        out_last_event
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_RD    = 6'b000010,
    ST_LD    = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_WR    = 6'b010000,
    ST_FLUSH = 6'b100000
  } state_t;

  localparam int WIdxW = $clog2(UsageWords);
  localparam int BIdxW = $clog2(WordBits);

  state_t                   state_r, state_nxt;
  report_t                  rpt_r;
  logic [WIdxW-1:0]         w_r, w_nxt;
  logic [BIdxW-1:0]         b_r, b_nxt;
  logic [WordBits-1:0]      work_r, work_nxt;
  logic [UsageWords-1:0]    valid_r, valid_nxt;
  logic [UsageWords-2:0]    nz_r, nz_nxt;
  logic [14:0]              sh7_r, sh7_nxt;
  logic [2:0]               sh4_r, sh4_nxt;
  logic                     pend_v_r, pend_v_nxt;
  logic [23:0]              pend_r, pend_nxt;
  logic                     ov_r, ov_nxt;
  logic [23:0]              oc_r, oc_nxt;
  logic                     ol_r, ol_nxt;
  logic [WordBits-1:0]      rdata;
  logic                     ram_we;

  logic [7:0]          u;
  logic                dbit, differ, emit, can_push, any_ns;
  logic [WordBits-1:0] wnew;
  logic [14:0]         m;
  logic [2:0]          l;
  logic [10:0]         nsh;
  logic [8:0]          osh;
  logic [23:0]         code;

  hrk_ram #(.WIDTH(WordBits), .DEPTH(UsageWords)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (w_r),
    .wdata (work_r),
    .raddr (w_r),
    .rdata (rdata)
  );

  assign u        = {w_r, b_r};
  assign can_push = !ov_r || out_ready;
  assign busy     = (state_r != ST_IDLE);
  assign ram_we   = (state_r == ST_WR);

  always_comb begin
    dbit = ((u == rpt_r.key_code_0) && (rpt_r.key_code_0 != 8'd0)) ||
           ((u == rpt_r.key_code_1) && (rpt_r.key_code_1 != 8'd0)) ||
           ((u == rpt_r.key_code_2) && (rpt_r.key_code_2 != 8'd0)) ||
           ((u == rpt_r.key_code_3) && (rpt_r.key_code_3 != 8'd0)) ||
           ((u == rpt_r.key_code_4) && (rpt_r.key_code_4 != 8'd0)) ||
           ((u == rpt_r.key_code_5) && (rpt_r.key_code_5 != 8'd0)) ||
           ((u[7:5] == 3'b111) && rpt_r.modifier_bits[u[2:0]] && (u[4:3] == 2'b00));
    differ = (work_r[b_r] != dbit);
    wnew = work_r;
    wnew[b_r] = dbit;

    // shift words and the non-shift summary after this bit's update
    m = (w_r == WIdxW'(7)) ? wnew[14:0] : sh7_r;
    l = (w_r == WIdxW'(4)) ? wnew[4:2] : sh4_r;
    any_ns = 1'b0;
    for (int j = 0; j < UsageWords - 1; j++) begin
      if (w_r == WIdxW'(j)) begin
        any_ns = any_ns | ((j == 4) ? |(wnew & W4_SHIFT_OFF) : |wnew);
      end else begin
        any_ns = any_ns | nz_r[j];
      end
    end

    nsh = {m[14], l[2], l[1], m[8] | m[9], m[3] | m[7], m[2] | m[6], m[0] | m[4],
           l[0], m[10] | m[11], m[12] | m[13], m[1] | m[5]};
    osh = {l[0], 1'b0, m[2] | m[6], m[4], m[0], m[11], m[10], m[5], m[1]};

    emit = 1'b0;
    code = '0;
    case (cfg.event_format)
      FMT_EIGHT: begin
        emit = 1'b1;
        code = {16'd0, rom_read(u, cfg.column_eight_bit) | (dbit ? EVT_DOWN_BIT : 8'd0)};
      end
      FMT_NEW: begin
        emit = 1'b1;
        if (dbit) begin
          code = EVT_NEW_BASE | {16'd0, rom_read(u, cfg.column_new)};
        end else if (is_shift(u) || any_ns) begin
          code = EVT_NEW_BASE | EVT_NEW_UP | {16'd0, rom_read(u, cfg.column_new)};
        end else begin
          code = EVT_NEW_BASE | EVT_NEW_ALL | {13'd0, nsh};
        end
      end
      FMT_OLD: begin
        emit = dbit && !is_shift(u);
        code = EVT_OLD_BASE | {15'd0, osh} | {16'd0, rom_read(u, cfg.column_old)};
      end
      default: emit = 1'b0;
    endcase
    emit = emit && differ;
  end

  always_comb begin
    state_nxt  = state_r;
    w_nxt      = w_r;
    b_nxt      = b_r;
    work_nxt   = work_r;
    valid_nxt  = valid_r;
    nz_nxt     = nz_r;
    sh7_nxt    = sh7_r;
    sh4_nxt    = sh4_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    ov_nxt     = ov_r && !out_ready;
    oc_nxt     = oc_r;
    ol_nxt     = ol_r;
    case (state_r)
      ST_IDLE: begin
        w_nxt = '0;
        if (rpt_load) state_nxt = ST_RD;
      end
      ST_RD: state_nxt = ST_LD;
      ST_LD: begin
        work_nxt  = valid_r[w_r] ? rdata : '0;
        b_nxt     = '0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        // hold the scan while the previous event has nowhere to go
        if (!(emit && pend_v_r && !can_push)) begin
          if (emit) begin
            if (pend_v_r) begin
              ov_nxt = 1'b1;
              oc_nxt = pend_r;
              ol_nxt = 1'b0;
            end
            pend_v_nxt = 1'b1;
            pend_nxt   = code;
          end
          work_nxt = wnew;
          b_nxt    = b_r + 1'b1;
          if (b_r == BIdxW'(WordBits - 1)) state_nxt = ST_WR;
        end
      end
      ST_WR: begin
        valid_nxt[w_r] = 1'b1;
        if (w_r == WIdxW'(7)) begin
          sh7_nxt   = work_r[14:0];
          state_nxt = ST_FLUSH;
        end else begin
          nz_nxt[w_r[WIdxW-1:0]] = (w_r == WIdxW'(4)) ? |(work_r & W4_SHIFT_OFF) : |work_r;
          if (w_r == WIdxW'(4)) sh4_nxt = work_r[4:2];
          w_nxt     = w_r + 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (can_push) begin
          ov_nxt     = 1'b1;
          oc_nxt     = pend_r;
          ol_nxt     = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      valid_r  <= '0;
      nz_r     <= '0;
      sh7_r    <= '0;
      sh4_r    <= '0;
      pend_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      valid_r  <= valid_nxt;
      nz_r     <= nz_nxt;
      sh7_r    <= sh7_nxt;
      sh4_r    <= sh4_nxt;
      pend_v_r <= pend_v_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rpt_load) rpt_r <= rpt;
    w_r    <= w_nxt;
    b_r    <= b_nxt;
    work_r <= work_nxt;
    pend_r <= pend_nxt;
    oc_r   <= oc_nxt;
    ol_r   <= ol_nxt;
  end

  assign out_valid      = ov_r;
  assign out_event_code = oc_r;
  assign out_last_event = ol_r;

endmodule

/* rtl/hid_report_to_keyboard_events.sv */
// Boot-keyboard report to key-event converter. Each accepted report is
// compared against the stored set of down usages, scanning usages 0x00 to
// 0xFF one per cycle in the bit steps while the event output does not
// stall. Each word of 32 usages is read from and written back to an
// 8-entry state RAM. For each of the 8 words the block reads, loads,
// runs 32 bit steps and writes back, then it flushes any pending event.
// A new report is taken only once the block is idle again. Both the scan
// and the flush hold while the event output is stalled. Events come out
// in usage order, and the final event of a report carries last_event.
// Configuration writes take effect at once and belong between reports.
module hid_report_to_keyboard_events
  import hrk_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_write_en,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [1:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_modifier_bits,
  input  logic [7:0]         in_key_code_0,
  input  logic [7:0]         in_key_code_1,
  input  logic [7:0]         in_key_code_2,
  input  logic [7:0]         in_key_code_3,
  input  logic [7:0]         in_key_code_4,
  input  logic [7:0]         in_key_code_5,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [23:0]        out_event_code,
  output logic               out_last_event
);

  cfg_t    cfg_r;
  report_t rpt;
  logic    busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{event_format: FMT_NEW, column_old: 2'd0, column_new: 2'd1,
                 column_eight_bit: 2'd3};
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_EVENT_FORMAT:     cfg_r.event_format     <= cfg_data;
        REG_COLUMN_OLD:       cfg_r.column_old       <= cfg_data;
        REG_COLUMN_NEW:       cfg_r.column_new       <= cfg_data;
        REG_COLUMN_EIGHT_BIT: cfg_r.column_eight_bit <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rpt = '{modifier_bits: in_modifier_bits, key_code_0: in_key_code_0,
                 key_code_1: in_key_code_1, key_code_2: in_key_code_2,
                 key_code_3: in_key_code_3, key_code_4: in_key_code_4,
                 key_code_5: in_key_code_5};
  assign in_ready = !busy;

  hrk_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .rpt_load       (in_valid && in_ready),
    .rpt            (rpt),
    .busy           (busy),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_code (out_event_code),
    .out_last_event (out_last_event)
  );

endmodule

/* rtl/hrk_checker.sv */
module hrk_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_event_code,
  input logic        out_last_event
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_code)
                                && $stable(out_last_event))
    else $error("held event changed while stalled");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a report transfer");

  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && out_valid |-> out_last_event)
    else $error("non-final event pending while idle");

endmodule

bind hid_report_to_keyboard_events hrk_checker u_hrk_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_event_code (out_event_code),
  .out_last_event (out_last_event)
);
